>>> rtl/lrpp_pkg.sv
`timescale 1ns / 1ps
// Package for the lidar range packet parser.
// Widths, packet layout constants and the structs shared by the parser modules.
package lrpp_pkg;

	localparam int BYTE_W     = 8;
	localparam int POS_W      = 5;
	localparam int PKT_LEN    = 22;
	localparam int STORE_LAST = 19;
	localparam int NUM_RDG    = 4;
	localparam int K_W        = 2;
	localparam int OFS_W      = 7;
	localparam int ANGLE_W    = 9;
	localparam int DIST_W     = 14;
	localparam int WORD_W     = 16;
	localparam int Q_DEPTH    = 2;
	localparam int Q_AW       = 1;
	localparam int CFG_IDX_W  = 8;

	localparam logic [POS_W-1:0]  POS_HUNT  = POS_W'(0);
	localparam logic [POS_W-1:0]  POS_FIRST = POS_W'(1);
	localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(PKT_LEN - 1);
	localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'hFA;
	localparam logic [BYTE_W-1:0] IDX_BASE  = 8'hA0;
	localparam logic [BYTE_W-1:0] IDX_TOP   = 8'hF9;
	localparam logic [OFS_W-1:0]  OFS_TOP   = OFS_W'(89);
	localparam logic [K_W-1:0]    K_LAST    = K_W'(NUM_RDG - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REPORT_READINGS     = 8'd0,
		CFG_REPORT_SPEED        = 8'd1,
		CFG_REPORT_PACKET_END   = 8'd2,
		CFG_REPORT_ROTATION_END = 8'd3
	} cfg_idx_t;

	typedef struct packed {
		logic report_readings;
		logic report_speed;
		logic report_packet_end;
		logic report_rotation_end;
	} cfg_t;

	// one decoded packet: index offset from base, speed, four raw readings
	typedef struct packed {
		logic [OFS_W-1:0]                ofs;
		logic [WORD_W-1:0]               speed;
		logic [NUM_RDG-1:0][2*WORD_W-1:0] rdg;
	} pkt_t;

	typedef struct packed {
		logic valid;
		pkt_t pkt;
	} q_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

>>> rtl/lrpp_byte_if.sv
`timescale 1ns / 1ps
// Byte stream channel of the lidar range packet parser.
// Depends on lrpp_pkg.
interface lrpp_byte_if;
	import lrpp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/lrpp_rdg_if.sv
`timescale 1ns / 1ps
// Reading result channel of the lidar range packet parser.
// Depends on lrpp_pkg.
interface lrpp_rdg_if;
	import lrpp_pkg::*;

	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] angle_deg;
	logic [DIST_W-1:0]  distance;
	logic               flag_bit6;
	logic               strength_warning;
	logic [WORD_W-1:0]  signal_strength;
	logic [WORD_W-1:0]  speed_raw;
	logic               speed_present;
	logic               last_in_packet;
	logic               rotation_end;

	modport source (output valid, output angle_deg, output distance, output flag_bit6,
		output strength_warning, output signal_strength, output speed_raw,
		output speed_present, output last_in_packet, output rotation_end, input ready);
	modport sink (input valid, input angle_deg, input distance, input flag_bit6,
		input strength_warning, input signal_strength, input speed_raw,
		input speed_present, input last_in_packet, input rotation_end, output ready);
endinterface

>>> rtl/lrpp_cfg_if.sv
`timescale 1ns / 1ps
// Register write channel of the lidar range packet parser.
// Depends on lrpp_pkg.
interface lrpp_cfg_if;
	import lrpp_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic                 data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/lidar_range_packet_parser_top.sv
`timescale 1ns / 1ps
// Top level of the lidar range packet parser: registers, front end, queue, back end.
// Depends on lrpp_pkg, the channel interfaces, lrpp_front, lrpp_fifo and lrpp_back.
//
//   port  role    beat
//   rx    sink    one received serial byte
//   rdg   source  one decoded reading
//   cfg   sink    one register write (index, bit 0 of data)
//
// A byte is taken every cycle; the last byte of a valid packet pushes one queue entry.
// Each entry gives four readings, one per cycle unless rdg stalls, from the
// back end output register. The two-entry queue stalls rx only on a last byte when full.
// rdg stalls hold the output register and the queue head; cfg is always ready.
// Reset: hunting for header, queue empty, all report registers set.
module lidar_range_packet_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	lrpp_byte_if.sink  rx,
	lrpp_rdg_if.source rdg,
	lrpp_cfg_if.sink   cfg
);
	import lrpp_pkg::*;

	cfg_t    cfg_q;
	q_push_t push;
	q_stat_t q_stat;
	pkt_t    head;
	logic    pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_REPORT_READINGS:     cfg_q.report_readings     <= cfg.data;
				CFG_REPORT_SPEED:        cfg_q.report_speed        <= cfg.data;
				CFG_REPORT_PACKET_END:   cfg_q.report_packet_end   <= cfg.data;
				CFG_REPORT_ROTATION_END: cfg_q.report_rotation_end <= cfg.data;
				default: ;
			endcase
		end
	end

	lrpp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.cfg    (cfg_q),
		.q_stat (q_stat),
		.push   (push)
	);

	lrpp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	lrpp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.rdg    (rdg)
	);

	a_q_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty together");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !q_stat.full)
		else $error("queue push while full");

	a_rot_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(rdg.valid && rdg.rotation_end) |-> (rdg.angle_deg == ANGLE_W'(359)))
		else $error("rotation end off angle 359");

	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rdg.valid && rdg.last_in_packet) |-> (rdg.angle_deg[K_W-1:0] == K_LAST))
		else $error("packet end on wrong reading");

	a_speed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rdg.valid && !rdg.speed_present) |-> (rdg.speed_raw == '0))
		else $error("speed given while not reported");

endmodule

>>> rtl/lrpp_front.sv
`timescale 1ns / 1ps
// Front end: header hunt, byte position tracking, packet assembly. Uses lrpp_pkg.
// Queues the packet on the last byte when the index is valid and readings are on.
module lrpp_front (
	input  logic             clk,
	input  logic             arst_n,
	lrpp_byte_if.sink        rx,
	input  lrpp_pkg::cfg_t   cfg,
	input  lrpp_pkg::q_stat_t q_stat,
	output lrpp_pkg::q_push_t push
);
	import lrpp_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] pkt_q [1:STORE_LAST];
	logic              acc;
	logic              idx_ok;

	assign rx.ready = !((pos_q == POS_LAST) && q_stat.full);
	assign acc      = rx.valid && rx.ready;
	assign idx_ok   = (pkt_q[1] >= IDX_BASE) && (pkt_q[1] <= IDX_TOP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
		end else if (acc) begin
			if (pos_q == POS_HUNT) begin
				pos_q <= (rx.rx_byte == HDR_BYTE) ? POS_FIRST : POS_HUNT;
			end else if (pos_q == POS_LAST) begin
				pos_q <= POS_HUNT;
			end else begin
				pos_q <= pos_q + POS_FIRST;
			end
		end
	end

	// checksum bytes are never stored
	always_ff @(posedge clk) begin
		for (int i = 1; i <= STORE_LAST; i++) begin
			if (acc && (pos_q == POS_W'(i))) begin
				pkt_q[i] <= rx.rx_byte;
			end
		end
	end

	always_comb begin
		push.valid     = acc && (pos_q == POS_LAST) && idx_ok && cfg.report_readings;
		push.pkt.ofs   = OFS_W'(pkt_q[1] - IDX_BASE);
		push.pkt.speed = {pkt_q[3], pkt_q[2]};
		for (int k = 0; k < NUM_RDG; k++) begin
			push.pkt.rdg[k] = {pkt_q[7 + 4*k], pkt_q[6 + 4*k], pkt_q[5 + 4*k], pkt_q[4 + 4*k]};
		end
	end

endmodule

>>> rtl/lrpp_fifo.sv
`timescale 1ns / 1ps
// Short packet queue between the front end and the reading emitter.
// Depends on lrpp_pkg.
module lrpp_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  lrpp_pkg::q_push_t push,
	input  logic              pop,
	output lrpp_pkg::pkt_t    head,
	output lrpp_pkg::q_stat_t q_stat
);
	import lrpp_pkg::*;

	pkt_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   cnt_q;

	assign q_stat.full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			if (push.valid && !pop) begin
				cnt_q <= cnt_q + (Q_AW+1)'(1);
			end else if (pop && !push.valid) begin
				cnt_q <= cnt_q - (Q_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.pkt;
		end
	end

endmodule

>>> rtl/lrpp_back.sv
`timescale 1ns / 1ps
// Back end: walks the four readings of the queue head into the output register.
// Depends on lrpp_pkg.
module lrpp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  lrpp_pkg::cfg_t    cfg,
	input  lrpp_pkg::pkt_t    head,
	input  lrpp_pkg::q_stat_t q_stat,
	output logic              pop,
	lrpp_rdg_if.source        rdg
);
	import lrpp_pkg::*;

	logic [K_W-1:0]      k_q;
	logic                out_valid_q;
	logic [ANGLE_W-1:0]  angle_q;
	logic [DIST_W-1:0]   dist_q;
	logic                flag6_q;
	logic                warn_q;
	logic [WORD_W-1:0]   strength_q;
	logic [WORD_W-1:0]   speed_q;
	logic                speed_pres_q;
	logic                last_q;
	logic                rot_q;
	logic                adv;
	logic [2*WORD_W-1:0] word;

	assign adv  = !q_stat.empty && (!out_valid_q || rdg.ready);
	assign pop  = adv && (k_q == K_LAST);
	assign word = head.rdg[k_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			k_q         <= k_q + K_W'(1);
			out_valid_q <= 1'b1;
		end else if (rdg.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_q      <= {head.ofs, k_q};
			dist_q       <= word[DIST_W-1:0];
			flag6_q      <= word[DIST_W];
			warn_q       <= word[DIST_W+1];
			strength_q   <= word[2*WORD_W-1:WORD_W];
			speed_q      <= cfg.report_speed ? head.speed : '0;
			speed_pres_q <= cfg.report_speed;
			last_q       <= cfg.report_packet_end && (k_q == K_LAST);
			rot_q        <= cfg.report_rotation_end && (k_q == K_LAST) && (head.ofs == OFS_TOP);
		end
	end

	assign rdg.valid            = out_valid_q;
	assign rdg.angle_deg        = angle_q;
	assign rdg.distance         = dist_q;
	assign rdg.flag_bit6        = flag6_q;
	assign rdg.strength_warning = warn_q;
	assign rdg.signal_strength  = strength_q;
	assign rdg.speed_raw        = speed_q;
	assign rdg.speed_present    = speed_pres_q;
	assign rdg.last_in_packet   = last_q;
	assign rdg.rotation_end     = rot_q;

endmodule
